[hdl/pimu_pkg.sv]
// Package for the priority-inheritance mutex unit: request kinds, status codes,
// controller state encoding and the command/status structs. No dependencies.
`default_nettype none
package pimu_pkg;
    localparam int NUM_TASKS_D   = 16;
    localparam int NUM_MUTEXES_D = 16;
    localparam int PRIO_LEVELS_D = 32;
    localparam int MAX_DEPTH     = 255;
    localparam int MAX_PRIO_RPT  = 17;

    localparam logic [1:0] K_LOCK   = 2'd0;
    localparam logic [1:0] K_UNLOCK = 2'd1;
    localparam logic [1:0] K_CANCEL = 2'd2;
    localparam logic [1:0] K_SETPRI = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_DEADLOCK = 3'd3;
    localparam logic [2:0] ST_RECURSE  = 3'd4;
    localparam logic [2:0] ST_NOTOWNER = 3'd5;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECIDE = 11'b00000000010,
        S_CYC    = 11'b00000000100,
        S_BOOST  = 11'b00000001000,
        S_ENQ    = 11'b00000010000,
        S_DEQ    = 11'b00000100000,
        S_HMAX   = 11'b00001000000,
        S_APPLY  = 11'b00010000000,
        S_DONE   = 11'b00100000000,
        S_ENQW   = 11'b01000000000,
        S_HAND   = 11'b10000000000
    } t_state;

    typedef struct packed {
        logic load;      // latch request
        logic decide;    // evaluate simple cases
        logic cyc_init;
        logic cyc_step;
        logic bst_init;
        logic bst_step;
        logic enq_init;
        logic enq_step;
        logic enq_link;
        logic deq_step;
        logic hm_init;
        logic hm_step;
        logic apply;     // commit level, report change
        logic hand;      // unlock handoff
        logic done;      // completion report
    } t_cmd;

    typedef struct packed {
        logic       is_bad;
        logic [1:0] kind;
        logic       need_walk;    // lock needs cycle check
        logic       need_unlock;  // final unlock
        logic       need_cancel;  // cancel of a live wait
        logic       cyc_end;
        logic       cyc_hit;
        logic       bst_end;
        logic       enq_end;
        logic       deq_end;
        logic       hm_end;
    } t_stat;
endpackage
`default_nettype wire

[hdl/pimu_dp.sv]
// Datapath of the priority-inheritance mutex unit: task and mutex tables,
// chain and list walkers, result register. Depends on pimu_pkg.
`default_nettype none
module pimu_dp #(
    parameter int NUM_TASKS   = pimu_pkg::NUM_TASKS_D,
    parameter int NUM_MUTEXES = pimu_pkg::NUM_MUTEXES_D,
    parameter int PRIO_LEVELS = pimu_pkg::PRIO_LEVELS_D
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  [1:0]       i_kind,
    input  wire  [3:0]       i_task_id,
    input  wire  [3:0]       i_mutex_id,
    input  wire              i_no_wait,
    input  wire  [4:0]       i_base_level,
    input  wire  pimu_pkg::t_cmd i_cmd,
    output pimu_pkg::t_stat  o_stat,
    output logic             o_strobe,
    output logic             o_report_kind,
    output logic [2:0]       o_status,
    output logic [3:0]       o_subject_task,
    output logic [4:0]       o_new_level,
    output logic             o_woken_valid,
    output logic [3:0]       o_woken_task,
    output logic             o_last
);
    import pimu_pkg::*;
    localparam int TW = $clog2(NUM_TASKS);
    localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int LW = $clog2(PRIO_LEVELS);
    localparam int GW = TW + 2;
    localparam logic [LW-1:0] LMAX = LW'(PRIO_LEVELS - 1);

    // tables; valid flags mark "some" for owner/head/next/waiting
    logic [TW-1:0] r_own [NUM_MUTEXES];
    logic          r_own_v [NUM_MUTEXES];
    logic [7:0]    r_dep [NUM_MUTEXES];
    logic [TW-1:0] r_head [NUM_MUTEXES];
    logic          r_head_v [NUM_MUTEXES];
    logic [TW-1:0] r_nxt [NUM_TASKS];
    logic          r_nxt_v [NUM_TASKS];
    logic [MW-1:0] r_won [NUM_TASKS];
    logic          r_won_v [NUM_TASKS];
    logic [LW-1:0] r_eff [NUM_TASKS];
    logic [LW-1:0] r_base [NUM_TASKS];

    logic [1:0]    r_kind;
    logic [TW-1:0] r_t;
    logic [MW-1:0] r_m;
    logic          r_nw;
    logic [LW-1:0] r_bl;
    logic          r_bad;
    logic [2:0]    r_st;
    logic          r_walk, r_unl, r_can;

    logic [TW-1:0] r_cur;
    logic          r_cur_v;
    logic [TW-1:0] r_prev;
    logic          r_prev_v;
    logic [GW-1:0] r_guard;
    logic [LW-1:0] r_lvl;
    logic [MW:0]   r_j;
    logic [4:0]    r_nrep;

    logic          bad_in;
    assign bad_in = (32'(i_task_id) >= NUM_TASKS) ||
                    ((i_kind != K_SETPRI) && (32'(i_mutex_id) >= NUM_MUTEXES));

    logic [MW-1:0] jm;
    assign jm = r_j[MW-1:0];
    logic          j_end;
    assign j_end = (32'(r_j) >= NUM_MUTEXES);

    logic [TW-1:0] nx_own;
    logic          nx_v;
    always_comb begin
        nx_own = r_own[r_won[r_cur]];
        nx_v   = r_won_v[r_cur] && r_own_v[r_won[r_cur]];
    end

    logic guard_ok;
    assign guard_ok = (32'(r_guard) <= NUM_TASKS);

    assign o_stat.is_bad      = r_bad;
    assign o_stat.kind        = r_kind;
    assign o_stat.need_walk   = r_walk;
    assign o_stat.need_unlock = r_unl;
    assign o_stat.need_cancel = r_can;
    assign o_stat.cyc_end     = !r_cur_v || !guard_ok || (r_cur == r_t);
    assign o_stat.cyc_hit     = r_cur_v;
    assign o_stat.bst_end     = !r_cur_v || !guard_ok;
    assign o_stat.enq_end     = !r_cur_v || (32'(r_guard) >= NUM_TASKS) ||
                                (r_eff[r_cur] < r_eff[r_t]);
    assign o_stat.deq_end     = !r_cur_v || (32'(r_guard) >= NUM_TASKS) ||
                                (r_nxt_v[r_cur] && r_nxt[r_cur] == r_t);
    assign o_stat.hm_end      = j_end;

    always_ff @(posedge i_clk) begin
        o_strobe <= 1'b0;
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_t    <= TW'(i_task_id);
            r_m    <= MW'(i_mutex_id);
            r_nw   <= i_no_wait;
            r_bl   <= (32'(i_base_level) >= PRIO_LEVELS) ? LMAX : LW'(i_base_level);
            r_bad  <= bad_in;
            r_st   <= ST_OK;
            r_walk <= 1'b0;
            r_unl  <= 1'b0;
            r_can  <= 1'b0;
            r_nrep <= '0;
        end
        if (i_cmd.decide) begin
            unique case (r_kind)
                K_LOCK: begin
                    if (r_won_v[r_t]) r_st <= ST_NOTOWNER;
                    else if (!r_own_v[r_m]) begin
                        r_own[r_m] <= r_t; r_own_v[r_m] <= 1'b1; r_dep[r_m] <= 8'd1;
                    end else if (r_own[r_m] == r_t) begin
                        if (r_dep[r_m] < 8'(MAX_DEPTH)) r_dep[r_m] <= r_dep[r_m] + 8'd1;
                        else r_st <= ST_RECURSE;
                    end else if (r_nw) r_st <= ST_TIMEOUT;
                    else r_walk <= 1'b1;
                end
                K_UNLOCK: begin
                    if (!r_own_v[r_m] || r_own[r_m] != r_t) r_st <= ST_NOTOWNER;
                    else if (r_dep[r_m] > 8'd1) r_dep[r_m] <= r_dep[r_m] - 8'd1;
                    else r_unl <= 1'b1;
                end
                K_CANCEL: begin
                    if (r_won_v[r_t] && r_won[r_t] == r_m) begin
                        r_can <= 1'b1; r_st <= ST_TIMEOUT;
                    end
                end
                default: r_base[r_t] <= r_bl;
            endcase
        end
        if (i_cmd.cyc_init || i_cmd.bst_init) begin
            r_cur   <= r_own[r_m];
            r_cur_v <= r_own_v[r_m];
            r_guard <= '0;
            r_lvl   <= r_eff[r_t];
        end
        if (i_cmd.cyc_step || i_cmd.bst_step) begin
            r_cur   <= nx_own;
            r_cur_v <= nx_v;
            r_guard <= r_guard + GW'(1);
        end
        if (i_cmd.cyc_init) r_st <= ST_OK;
        if (i_cmd.bst_step) begin
            if (r_eff[r_cur] < r_lvl) begin
                r_eff[r_cur] <= r_lvl;
                if (32'(r_nrep) < MAX_PRIO_RPT) begin
                    r_nrep <= r_nrep + 5'd1;
                    o_strobe <= 1'b1; o_report_kind <= 1'b0; o_status <= ST_OK;
                    o_subject_task <= 4'(r_cur); o_new_level <= 5'(r_lvl);
                    o_woken_valid <= 1'b0; o_woken_task <= '0; o_last <= 1'b0;
                end
            end else if (r_eff[r_cur] > r_lvl) r_lvl <= r_eff[r_cur];
        end
        if (i_cmd.enq_init) begin
            r_cur    <= r_head[r_m];
            r_cur_v  <= r_head_v[r_m];
            r_prev_v <= 1'b0;
            r_guard  <= '0;
        end
        if (i_cmd.enq_step) begin
            r_prev   <= r_cur;
            r_prev_v <= 1'b1;
            r_cur    <= r_nxt[r_cur];
            r_cur_v  <= r_nxt_v[r_cur];
            r_guard  <= r_guard + GW'(1);
        end
        if (i_cmd.enq_link) begin
            r_won[r_t]   <= r_m;
            r_won_v[r_t] <= 1'b1;
            r_nxt[r_t]   <= r_cur;
            r_nxt_v[r_t] <= r_cur_v;
            if (!r_prev_v) begin
                r_head[r_m] <= r_t; r_head_v[r_m] <= 1'b1;
            end else begin
                r_nxt[r_prev] <= r_t; r_nxt_v[r_prev] <= 1'b1;
            end
            r_st <= ST_QUEUED;
        end
        if (i_cmd.deq_step) begin
            if (r_head_v[r_m] && r_head[r_m] == r_t && r_guard == '0 && r_cur == r_t
                && r_cur_v) begin
                r_head[r_m] <= r_nxt[r_t]; r_head_v[r_m] <= r_nxt_v[r_t];
                r_nxt_v[r_t] <= 1'b0; r_won_v[r_t] <= 1'b0;
            end else if (o_stat.deq_end) begin
                if (r_cur_v && r_nxt_v[r_cur] && r_nxt[r_cur] == r_t) begin
                    r_nxt[r_cur] <= r_nxt[r_t]; r_nxt_v[r_cur] <= r_nxt_v[r_t];
                end
                r_nxt_v[r_t] <= 1'b0; r_won_v[r_t] <= 1'b0;
            end else begin
                r_cur   <= r_nxt[r_cur];
                r_cur_v <= r_nxt_v[r_cur];
                r_guard <= r_guard + GW'(1);
            end
        end
        if (i_cmd.hm_init) begin
            r_j   <= '0;
            r_lvl <= (r_kind == K_SETPRI) ? r_bl : r_base[r_t];
        end
        if (i_cmd.hm_step && !j_end) begin
            r_j <= r_j + (MW+1)'(1);
            if (!(r_kind == K_UNLOCK && jm == r_m) && r_own_v[jm] && r_own[jm] == r_t
                && r_head_v[jm] && r_eff[r_head[jm]] > r_lvl)
                r_lvl <= r_eff[r_head[jm]];
        end
        if (i_cmd.apply && r_eff[r_t] != r_lvl) begin
            r_eff[r_t] <= r_lvl;
            if (32'(r_nrep) < MAX_PRIO_RPT) begin
                r_nrep <= r_nrep + 5'd1;
                o_strobe <= 1'b1; o_report_kind <= 1'b0; o_status <= ST_OK;
                o_subject_task <= 4'(r_t); o_new_level <= 5'(r_lvl);
                o_woken_valid <= 1'b0; o_woken_task <= '0; o_last <= 1'b0;
            end
        end
        if (i_cmd.hand) begin
            o_woken_valid <= r_head_v[r_m];
            o_woken_task  <= r_head_v[r_m] ? 4'(r_head[r_m]) : 4'd0;
            if (r_head_v[r_m]) begin
                r_head[r_m]   <= r_nxt[r_head[r_m]];
                r_head_v[r_m] <= r_nxt_v[r_head[r_m]];
                r_nxt_v[r_head[r_m]] <= 1'b0;
                r_won_v[r_head[r_m]] <= 1'b0;
                r_own[r_m] <= r_head[r_m];
                r_dep[r_m] <= 8'd1;
            end else begin
                r_head_v[r_m] <= 1'b0;
                r_own_v[r_m]  <= 1'b0;
                r_dep[r_m]    <= 8'd0;
            end
        end
        if (i_cmd.done) begin
            o_strobe <= 1'b1; o_report_kind <= 1'b1;
            o_status <= r_bad ? ST_NOTOWNER : r_st;
            o_subject_task <= '0; o_new_level <= '0; o_last <= 1'b1;
            if (!(r_unl && !r_bad)) begin
                o_woken_valid <= 1'b0; o_woken_task <= '0;
            end
        end
        if (i_cmd.cyc_step && o_stat.cyc_end) r_st <= ST_DEADLOCK;
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
            for (int i = 0; i < NUM_MUTEXES; i++) begin
                r_own_v[i] <= 1'b0; r_head_v[i] <= 1'b0; r_dep[i] <= 8'd0;
            end
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_nxt_v[i] <= 1'b0; r_won_v[i] <= 1'b0;
                r_eff[i] <= '0; r_base[i] <= '0;
            end
        end
    end
endmodule
`default_nettype wire

[hdl/pimu_ctrl.sv]
// Controller of the priority-inheritance mutex unit: sequences each request
// through the datapath walkers. Depends on pimu_pkg.
`default_nettype none
module pimu_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  wire  pimu_pkg::t_stat i_stat,
    output pimu_pkg::t_cmd   o_cmd
);
    import pimu_pkg::*;
    t_state r_state, n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) begin
                o_cmd.load = 1'b1; n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.is_bad) n_state = S_DONE;
                else begin
                    o_cmd.decide = 1'b1;
                    n_state = S_ENQW;
                end
            end
            S_ENQW: begin
                if (i_stat.need_walk) begin
                    o_cmd.cyc_init = 1'b1; n_state = S_CYC;
                end else if (i_stat.need_unlock || i_stat.kind == K_SETPRI) begin
                    o_cmd.hm_init = 1'b1; n_state = S_HMAX;
                end else if (i_stat.need_cancel) begin
                    o_cmd.enq_init = 1'b1; n_state = S_DEQ;
                end else n_state = S_DONE;
            end
            S_CYC: begin
                o_cmd.cyc_step = 1'b1;
                if (i_stat.cyc_end) begin
                    if (i_stat.cyc_hit) n_state = S_DONE;
                    else begin
                        o_cmd.cyc_step = 1'b0; o_cmd.bst_init = 1'b1; n_state = S_BOOST;
                    end
                end
            end
            S_BOOST: begin
                if (i_stat.bst_end) begin
                    o_cmd.enq_init = 1'b1; n_state = S_ENQ;
                end else o_cmd.bst_step = 1'b1;
            end
            S_ENQ: begin
                if (i_stat.enq_end) begin
                    o_cmd.enq_link = 1'b1; n_state = S_DONE;
                end else o_cmd.enq_step = 1'b1;
            end
            S_DEQ: begin
                o_cmd.deq_step = 1'b1;
                if (i_stat.deq_end) n_state = S_DONE;
            end
            S_HMAX: begin
                o_cmd.hm_step = 1'b1;
                if (i_stat.hm_end) n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = i_stat.need_unlock ? S_HAND : S_DONE;
            end
            S_HAND: begin
                o_cmd.hand = 1'b1; n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> !busy) else $error("done did not return to idle");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (start && !busy)) else $error("load without start");
endmodule
`default_nettype wire

[hdl/priority_inheritance_mutex_unit.sv]
// Top level of the priority-inheritance mutex unit: controller plus datapath.
// The completion strobe ends each request; a blocking lock first runs the cycle,
// boost and list walks, a final unlock the holder scan and handoff; priority reports
// come before the strobe, one a cycle.
// One request at a time: busy drops as the completion strobe rises; no stall input.
// Synchronous active-low reset clears all tables at once. Depends on pimu_pkg.
`default_nettype none
module priority_inheritance_mutex_unit #(
    parameter int NUM_TASKS   = pimu_pkg::NUM_TASKS_D,
    parameter int NUM_MUTEXES = pimu_pkg::NUM_MUTEXES_D,
    parameter int PRIO_LEVELS = pimu_pkg::PRIO_LEVELS_D
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire  [1:0] i_kind,
    input  wire  [3:0] i_task_id,
    input  wire  [3:0] i_mutex_id,
    input  wire        i_no_wait,
    input  wire  [4:0] i_base_level,
    output logic       o_strobe,
    output logic       o_report_kind,
    output logic [2:0] o_status,
    output logic [3:0] o_subject_task,
    output logic [4:0] o_new_level,
    output logic       o_woken_valid,
    output logic [3:0] o_woken_task,
    output logic       o_last
);
    import pimu_pkg::*;
    t_cmd  cmd;
    t_stat stat;

    pimu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    pimu_dp #(.NUM_TASKS(NUM_TASKS), .NUM_MUTEXES(NUM_MUTEXES),
              .PRIO_LEVELS(PRIO_LEVELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_kind(i_kind), .i_task_id(i_task_id), .i_mutex_id(i_mutex_id),
        .i_no_wait(i_no_wait), .i_base_level(i_base_level),
        .i_cmd(cmd), .o_stat(stat),
        .o_strobe(o_strobe), .o_report_kind(o_report_kind), .o_status(o_status),
        .o_subject_task(o_subject_task), .o_new_level(o_new_level),
        .o_woken_valid(o_woken_valid), .o_woken_task(o_woken_task), .o_last(o_last)
    );
endmodule
`default_nettype wire
